// ----- rtl/core/spq_pkg.sv -----
// Package for the stable sorted priority queue: sizes, operation codes and
// the structs that pass between the top level and the row of slot cells.
// Depends on nothing.
`default_nettype none

package spq_pkg;

  // Number of slots in the queue.
  localparam int unsigned Capacity    = 16;
  // Width of a priority value.
  localparam int unsigned SevBits     = 8;
  // Width of the stored tag.
  localparam int unsigned PayloadBits = 16;

  // Operation codes on the input channel.
  typedef enum logic [0:0] {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } op_e;

  // Contents of one slot.
  typedef struct packed {
    logic                   valid;
    logic [SevBits-1:0]     sev;
    logic [PayloadBits-1:0] tag;
  } entry_t;

  // Command that is broadcast to every cell in the cycle of a transfer.
  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic [SevBits-1:0]     sev;
    logic [PayloadBits-1:0] tag;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/stable_sorted_priority_queue_top.sv -----
// Top level of the stable sorted priority queue: the row of slot cells and
// the result register with its handshake.
// Depends on spq_pkg and spq_cell.
//
// Usage: an item on the input channel (op_i, severity_i, payload_i) is
// transferred when in_valid_i and in_ready_o are both high. An insert puts
// the entry behind every queued entry with a priority no larger, so equal
// priorities leave in arrival order; a removal takes the front entry.
// Every item yields one result on the output channel (ok_o,
// out_severity_o, out_payload_o, now_empty_o, now_full_o), transferred
// when out_valid_o and out_ready_i are both high.
// The result is registered and valid in the cycle after the input
// transfer. The queue takes one item per cycle while the receiver keeps up;
// the row of cells all compare against the new priority and shift together.
// When the receiver stalls, the result waits in the output register and
// in_ready_o stays low until it is taken; a result taken in a cycle frees
// the register for the next input in that same cycle.
// Reset clears every slot's valid bit and the output valid flag: the queue
// starts empty, with no result pending.
`default_nettype none

module stable_sorted_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  severity_i,
  input  logic [15:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [7:0]  out_severity_o,
  output logic [15:0] out_payload_o,
  output logic        now_empty_o,
  output logic        now_full_o
);

  localparam int unsigned Cap = spq_pkg::Capacity;

  spq_pkg::entry_t [Cap-1:0] cell_entry;
  logic            [Cap-1:0] cell_behind;
  logic            [Cap-1:0] cell_valid;
  spq_pkg::cmd_t             cmd;
  spq_pkg::op_e              op;
  logic                      in_fire;
  logic                      q_empty;
  logic                      q_full;

  logic                        out_valid_q, out_valid_d;
  logic                        ok_q, ok_d;
  logic [spq_pkg::SevBits-1:0] sev_q, sev_d;
  logic [15:0]                 payload_q, payload_d;
  logic                        empty_q, empty_d;
  logic                        full_q, full_d;

  assign op      = spq_pkg::op_e'(op_i);
  assign in_fire = in_valid_i && in_ready_o;

  // The output register takes a new result when empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;

  // Occupancy follows from the valid bits, which fill from the front.
  always_comb begin
    for (int i = 0; i < Cap; i++) begin
      cell_valid[i] = cell_entry[i].valid;
    end
  end
  assign q_empty = !cell_valid[0];
  assign q_full  = cell_valid[Cap-1];

  // Command broadcast to the cells; a blocked operation leaves them alone.
  always_comb begin
    cmd.ins = in_fire && (op == spq_pkg::OpInsert) && !q_full;
    cmd.rem = in_fire && (op == spq_pkg::OpRemove) && !q_empty;
    cmd.sev = severity_i;
    cmd.tag = payload_i[spq_pkg::PayloadBits-1:0];
  end

  // Row of slot cells, front at index zero.
  for (genvar g = 0; g < Cap; g++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_behind;

    if (g == 0) begin : g_front
      assign left_entry  = '0;
      assign left_behind = 1'b1;
    end else begin : g_mid
      assign left_entry  = cell_entry[g-1];
      assign left_behind = cell_behind[g-1];
    end

    if (g == Cap - 1) begin : g_back
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_i       (left_entry),
      .left_behind_i(left_behind),
      .right_i      (right_entry),
      .entry_o      (cell_entry[g]),
      .behind_o     (cell_behind[g])
    );
  end

  // Build the result of the operation being transferred.
  always_comb begin
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    sev_d       = sev_q;
    payload_d   = payload_q;
    empty_d     = empty_q;
    full_d      = full_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d = 1'b1;
      sev_d       = '0;
      payload_d   = '0;
      if (op == spq_pkg::OpInsert) begin
        ok_d    = !q_full;
        empty_d = 1'b0;
        full_d  = q_full || cell_valid[Cap-2];
      end else begin
        ok_d    = !q_empty;
        empty_d = !cell_valid[1];
        full_d  = 1'b0;
        if (!q_empty) begin
          sev_d     = cell_entry[0].sev;
          payload_d = 16'(cell_entry[0].tag);
        end
      end
    end
  end

  // Output handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    ok_q      <= ok_d;
    sev_q     <= sev_d;
    payload_q <= payload_d;
    empty_q   <= empty_d;
    full_q    <= full_d;
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign out_severity_o = sev_q;
  assign out_payload_o  = payload_q;
  assign now_empty_o    = empty_q;
  assign now_full_o     = full_q;

  // Checks on the row: valid slots are packed at the front and sorted.
  logic holes;
  logic unsorted;
  always_comb begin
    holes    = 1'b0;
    unsorted = 1'b0;
    for (int i = 1; i < Cap; i++) begin
      if (cell_valid[i] && !cell_valid[i-1]) begin
        holes = 1'b1;
      end
      if (cell_valid[i] && (cell_entry[i].sev < cell_entry[i-1].sev)) begin
        unsorted = 1'b1;
      end
    end
  end

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni) !holes)
    else $error("valid slots are not packed at the front");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni) !unsorted)
    else $error("queued priorities are out of order");

  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_fire && op_i && q_empty) |=> (out_valid_o && !ok_o && now_empty_o))
    else $error("removal on an empty queue did not report failure");

  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_fire && !op_i && q_full) |=> (q_full && !ok_o && now_full_o))
    else $error("insert on a full queue changed the queue or reported success");

endmodule

`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted queue. It keeps its entry, takes the new entry,
// takes its left neighbor's entry on an insert, or its right neighbor's on a removal.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spq_pkg::cmd_t   cmd_i,
  input  spq_pkg::entry_t left_i,
  input  logic            left_behind_i,
  input  spq_pkg::entry_t right_i,
  output spq_pkg::entry_t entry_o,
  output logic            behind_o
);

  logic                            valid_q;
  logic [spq_pkg::SevBits-1:0]     sev_q;
  logic [spq_pkg::PayloadBits-1:0] tag_q;
  spq_pkg::entry_t                 entry_q, entry_d;

  assign entry_q = {valid_q, sev_q, tag_q};

  // The new entry goes behind this slot if it holds a priority no larger.
  assign behind_o = entry_q.valid && (entry_q.sev <= cmd_i.sev);

  // Choose the next contents of the slot.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (!behind_o) begin
        if (left_behind_i) begin
          entry_d.valid = 1'b1;
          entry_d.sev   = cmd_i.sev;
          entry_d.tag   = cmd_i.tag;
        end else begin
          entry_d = left_i;
        end
      end
    end else if (cmd_i.rem) begin
      entry_d = right_i;
    end
  end

  // The valid bit is control state and is cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  // Priority and tag carry no reset.
  always_ff @(posedge clk_i) begin
    sev_q <= entry_d.sev;
    tag_q <= entry_d.tag;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- tb/stable_sorted_priority_queue_top_tb.sv -----
// Testbench for the stable sorted priority queue: a directed table, then random
// insert/remove traffic, with each result compared against the in-bench queue model or the table.
// Depends on spq_pkg and stable_sorted_priority_queue_top.
`default_nettype none

module stable_sorted_priority_queue_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned RandomItems = 930;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DirectedLen = 20;

  // One result as it appears on the output channel.
  typedef struct packed {
    logic                            ok;
    logic [spq_pkg::SevBits-1:0]     sev;
    logic [spq_pkg::PayloadBits-1:0] tag;
    logic                            empty;
    logic                            full;
  } outcome_t;

  // One row of the directed table; the typed outcome is used only when known is set.
  typedef struct packed {
    spq_pkg::op_e                    op;
    logic [spq_pkg::SevBits-1:0]     sev;
    logic [spq_pkg::PayloadBits-1:0] tag;
    logic                            known;
    outcome_t                        res;
  } step_row_t;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            in_valid_i     = 1'b0;
  logic                            in_ready_o;
  logic                            op_i           = 1'b0;
  logic [spq_pkg::SevBits-1:0]     severity_i     = '0;
  logic [spq_pkg::PayloadBits-1:0] payload_i      = '0;
  logic                            out_valid_o;
  logic                            out_ready_i    = 1'b0;
  logic                            ok_o;
  logic [spq_pkg::SevBits-1:0]     out_severity_o;
  logic [spq_pkg::PayloadBits-1:0] out_payload_o;
  logic                            now_empty_o;
  logic                            now_full_o;

  // Queue model: sorted priorities and tags, plus the number of entries held.
  logic [spq_pkg::SevBits-1:0]     held_sev [spq_pkg::Capacity];
  logic [spq_pkg::PayloadBits-1:0] held_tag [spq_pkg::Capacity];
  int unsigned                     held_count = 0;

  outcome_t    expected_results [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned ready_mode  = 0;
  int unsigned ready_left  = 0;

  // Directed table: empty removal, extremes and ties, fill to the top, overflow, one removal, refill.
  step_row_t directed_rows [DirectedLen] = '{
    '{spq_pkg::OpRemove, 8'hff, 16'hffff, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b1, 1'b0}},
    '{spq_pkg::OpInsert, 8'hff, 16'hffff, 1'b1, '{1'b1, 8'h00, 16'h0000, 1'b0, 1'b0}},
    '{spq_pkg::OpInsert, 8'h00, 16'h0000, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h80, 16'ha5a5, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h80, 16'h5a5a, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h00, 16'h1234, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'hff, 16'h0001, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h80, 16'h8000, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h01, 16'hfffe, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'hfe, 16'h00ff, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h7f, 16'h7fff, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h80, 16'hff00, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h00, 16'h0f0f, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h55, 16'haaaa, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'haa, 16'h5555, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h80, 16'hc3c3, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h00, 16'h3c3c, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h0c, 16'hbeef, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 1'b1}},
    '{spq_pkg::OpRemove, 8'h00, 16'h0000, 1'b0, '0},
    '{spq_pkg::OpInsert, 8'h00, 16'hdead, 1'b0, '0}
  };

  stable_sorted_priority_queue_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .severity_i    (severity_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .out_severity_o(out_severity_o),
    .out_payload_o (out_payload_o),
    .now_empty_o   (now_empty_o),
    .now_full_o    (now_full_o)
  );

  // Free-running clock.
  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Applies one operation to the queue model and returns the result it yields.
  function automatic outcome_t queue_step(spq_pkg::op_e op,
                                          logic [spq_pkg::SevBits-1:0] sev,
                                          logic [spq_pkg::PayloadBits-1:0] tag);
    outcome_t    res;
    int unsigned pos;
    int unsigned i;
    res = '0;
    if (op == spq_pkg::OpInsert) begin
      if (held_count < spq_pkg::Capacity) begin
        // New entry goes behind every entry with a priority no larger.
        pos = 0;
        while (pos < held_count && held_sev[pos] <= sev) pos++;
        for (i = held_count; i > pos; i--) begin
          held_sev[i] = held_sev[i-1];
          held_tag[i] = held_tag[i-1];
        end
        held_sev[pos] = sev;
        held_tag[pos] = tag;
        held_count++;
        res.ok = 1'b1;
      end
    end else if (held_count != 0) begin
      res.ok  = 1'b1;
      res.sev = held_sev[0];
      res.tag = held_tag[0];
      for (i = 1; i < held_count; i++) begin
        held_sev[i-1] = held_sev[i];
        held_tag[i-1] = held_tag[i];
      end
      held_count--;
    end
    res.empty = (held_count == 0);
    res.full  = (held_count >= spq_pkg::Capacity);
    return res;
  endfunction

  // Presents one item and holds it until the transfer, then records what it should yield.
  task automatic transfer_item(spq_pkg::op_e op, logic [spq_pkg::SevBits-1:0] sev,
                               logic [spq_pkg::PayloadBits-1:0] tag, logic known,
                               outcome_t res);
    outcome_t predicted;
    in_valid_i <= 1'b1;
    op_i       <= op;
    severity_i <= sev;
    payload_i  <= tag;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = queue_step(op, sev, tag);
    expected_results.push_back(known ? res : predicted);
  endtask

  // Sender pacing: bursts of random length, some followed by an idle gap.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Cycle counter for the receiver pattern and the watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver: switches among always ready, random, mostly stalled and a fixed pattern.
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(3);
      ready_left <= $urandom_range(80, 20);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= 1'($urandom_range(1));
      end
      2: begin
        out_ready_i <= ($urandom_range(7) == 0);
      end
      default: begin
        out_ready_i <= (cycle_count[2:0] != 3'd0) && cycle_count[4];
      end
    endcase
  end

  // Output monitor: each result transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no expectation pending");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("ok", 32'(want.ok), 32'(ok_o));
        check_field("out_severity", 32'(want.sev), 32'(out_severity_o));
        check_field("out_payload", 32'(want.tag), 32'(out_payload_o));
        check_field("now_empty", 32'(want.empty), 32'(now_empty_o));
        check_field("now_full", 32'(want.full), 32'(now_full_o));
      end
    end
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus: reset, directed table, then random traffic.
  initial begin
    int unsigned  n;
    int unsigned  insert_pct;
    spq_pkg::op_e op;
    logic [7:0]   sev;
    insert_pct = 50;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < DirectedLen; n++) begin
      transfer_item(directed_rows[n].op, directed_rows[n].sev, directed_rows[n].tag,
                    directed_rows[n].known, directed_rows[n].res);
      pace_sender();
    end

    // Random traffic drifts between filling, draining and balanced phases so the
    // queue reaches both full and empty many times.
    for (n = 0; n < RandomItems; n++) begin
      if (n % 48 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
      end
      op = ($urandom_range(99) < insert_pct) ? spq_pkg::OpInsert : spq_pkg::OpRemove;
      // Narrow priorities give many ties; extremes and full range fill the rest.
      case ($urandom_range(3))
        0: sev = 8'($urandom_range(3));
        1: sev = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
        default: sev = 8'($urandom_range(255));
      endcase
      transfer_item(op, sev, 16'($urandom_range(16'hffff)), 1'b0, '0);
      pace_sender();
    end
    in_valid_i <= 1'b0;

    // Drain, then give a stray result time to show up.
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
